// ===== hdl/chull_pkg.sv =====
// ----------------------------------------------------------------------------
// chull_pkg
// Shared constants, types and sequencer states of the convex hull core.
// ----------------------------------------------------------------------------
package chull_pkg;

  localparam int MAX_POINTS  = 32;
  localparam int COORD_BITS  = 16;
  localparam int FIELD_W     = 16;
  localparam int MAX_RESULTS = 32;

  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int STACK_DEPTH = 2 * MAX_POINTS;
  localparam int SIDX_W      = $clog2(STACK_DEPTH);
  localparam int SDEP_W      = $clog2(STACK_DEPTH + 1);
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_CHK,
    S_SORT_CMP,
    S_HINIT,
    S_H_RI,
    S_H_LAT,
    S_H_CHK,
    S_H_DIFF,
    S_H_MUL,
    S_H_CMP,
    S_H_SLAT,
    S_H_PUSH,
    S_EMIT,
    S_E_RS,
    S_E_RP,
    S_E_OUT
  } state_t;

endpackage

// ===== hdl/chull_if.sv =====
// ----------------------------------------------------------------------------
// chull_in_if / chull_out_if
// Valid/ready channels for loaded points and emitted hull vertices.
// ----------------------------------------------------------------------------
interface chull_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic               last_point;

  modport source(output valid, point_x, point_y, last_point, input ready);
  modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

interface chull_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hull_x;
  logic signed [15:0] hull_y;
  logic               last_vertex;
  logic               overflowed;

  modport source(output valid, hull_x, hull_y, last_vertex, overflowed, input ready);
  modport sink(input valid, hull_x, hull_y, last_vertex, overflowed, output ready);
endinterface

// ===== hdl/chull_front.sv =====
// ----------------------------------------------------------------------------
// chull_front
// Accepts point requests, narrows coordinates and queues them for the engine.
// ----------------------------------------------------------------------------
module chull_front (
  input  logic             clk,
  input  logic             rst,
  chull_in_if.sink         pts,
  output logic             q_valid,
  output chull_pkg::item_t q_item,
  input  logic             q_ready
);

  chull_pkg::item_t                     queue [chull_pkg::QUEUE_DEPTH];
  logic [chull_pkg::QPTR_W-1:0]         wr_ptr;
  logic [chull_pkg::QPTR_W-1:0]         rd_ptr;
  logic [chull_pkg::QCNT_W-1:0]         fill;
  logic                                 push;
  logic                                 pop;
  chull_pkg::item_t                     in_item;

  assign pts.ready = (fill < chull_pkg::QCNT_W'(chull_pkg::QUEUE_DEPTH));
  assign push      = pts.valid && pts.ready;
  assign q_valid   = (fill != '0);
  assign pop       = q_valid && q_ready;
  assign q_item    = queue[rd_ptr];

  // low COORD_BITS of each field, two's complement
  always_comb begin
    in_item.x    = chull_pkg::coord_t'(pts.point_x[chull_pkg::COORD_BITS-1:0]);
    in_item.y    = chull_pkg::coord_t'(pts.point_y[chull_pkg::COORD_BITS-1:0]);
    in_item.last = pts.last_point;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// ===== hdl/chull_engine.sv =====
// ----------------------------------------------------------------------------
// chull_engine
// Insertion sort into the point store, monotone chain hull passes on a
// stack of store indices, and vertex emission through an output register.
// ----------------------------------------------------------------------------
module chull_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  chull_pkg::item_t q_item,
  output logic             q_ready,
  chull_out_if.source      hull
);

  chull_pkg::state_t state, state_next;

  chull_pkg::pt_t                      pmem [chull_pkg::MAX_POINTS];
  logic [chull_pkg::IDX_W-1:0]         smem [chull_pkg::STACK_DEPTH];

  chull_pkg::pt_t                      rd_a, rd_b;
  logic [chull_pkg::IDX_W-1:0]         srd;
  logic [chull_pkg::IDX_W-1:0]         addr_a, addr_b;
  logic [chull_pkg::SIDX_W-1:0]        saddr;

  chull_pkg::item_t                    cur;
  logic [chull_pkg::CNT_W-1:0]         count;
  logic                                ovf;
  logic [chull_pkg::CNT_W-1:0]         k;
  logic [chull_pkg::CNT_W-1:0]         i;
  logic                                upper;
  logic [chull_pkg::SDEP_W-1:0]        depth;
  logic [chull_pkg::SDEP_W-1:0]        t;
  logic [chull_pkg::SDEP_W-1:0]        emit_n;
  logic [chull_pkg::IDX_W-1:0]         top_i, sec_i;
  chull_pkg::pt_t                      pi;
  logic signed [chull_pkg::DIFF_W-1:0] ax, ay, bx, by;
  logic signed [chull_pkg::PROD_W-1:0] m1, m2;

  logic                                ov;
  chull_pkg::pt_t                      ov_pt;
  logic                                ov_last, ov_ovf;

  logic                                precedes;
  logic                                cw;
  logic                                pop_ok;
  logic [chull_pkg::SDEP_W-1:0]        floor_d;
  logic                                can_push;
  logic [chull_pkg::SDEP_W-1:0]        depth_pushed;
  logic [chull_pkg::SDEP_W-1:0]        e_raw, e_cnt;
  logic                                load_out;
  logic                                full;

  assign full     = (count == chull_pkg::CNT_W'(chull_pkg::MAX_POINTS));
  assign precedes = (cur.x < rd_a.x) || ((cur.x == rd_a.x) && (cur.y < rd_a.y));
  assign cw       = (m1 < m2);
  assign floor_d  = upper ? t : chull_pkg::SDEP_W'(1);
  assign pop_ok   = (depth >= chull_pkg::SDEP_W'(2)) && (depth > floor_d);
  assign can_push = (depth < chull_pkg::SDEP_W'(chull_pkg::STACK_DEPTH));
  assign depth_pushed = can_push ? depth + 1'b1 : depth;
  assign e_raw    = (count >= chull_pkg::CNT_W'(2)) ? depth - 1'b1 : depth;
  assign e_cnt    = (e_raw > chull_pkg::SDEP_W'(chull_pkg::MAX_RESULTS))
                    ? chull_pkg::SDEP_W'(chull_pkg::MAX_RESULTS) : e_raw;
  assign q_ready  = (state == chull_pkg::S_IDLE);
  assign load_out = (state == chull_pkg::S_E_OUT) && (!ov || hull.ready);

  // memory read ports: address follows the state
  always_comb begin
    addr_a = srd;
    addr_b = sec_i;
    saddr  = chull_pkg::SIDX_W'(k);
    case (state)
      chull_pkg::S_SORT_CHK: addr_a = chull_pkg::IDX_W'(k - 1'b1);
      chull_pkg::S_H_RI:     addr_a = chull_pkg::IDX_W'(i);
      chull_pkg::S_H_CHK:    addr_a = top_i;
      chull_pkg::S_H_CMP:    saddr  = chull_pkg::SIDX_W'(depth - chull_pkg::SDEP_W'(3));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_a <= pmem[addr_a];
    rd_b <= pmem[addr_b];
    srd  <= smem[saddr];
  end

  always_ff @(posedge clk) begin
    state <= rst ? chull_pkg::S_IDLE : state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      chull_pkg::S_IDLE: begin
        if (q_valid) begin
          if (!full)         state_next = chull_pkg::S_SORT_CHK;
          else if (q_item.last) state_next = chull_pkg::S_HINIT;
        end
      end
      chull_pkg::S_SORT_CHK: begin
        if (k == '0) state_next = cur.last ? chull_pkg::S_HINIT : chull_pkg::S_IDLE;
        else         state_next = chull_pkg::S_SORT_CMP;
      end
      chull_pkg::S_SORT_CMP: begin
        if (precedes) state_next = chull_pkg::S_SORT_CHK;
        else          state_next = cur.last ? chull_pkg::S_HINIT : chull_pkg::S_IDLE;
      end
      chull_pkg::S_HINIT:  state_next = (count == '0) ? chull_pkg::S_EMIT : chull_pkg::S_H_RI;
      chull_pkg::S_H_RI:   state_next = chull_pkg::S_H_LAT;
      chull_pkg::S_H_LAT:  state_next = chull_pkg::S_H_CHK;
      chull_pkg::S_H_CHK:  state_next = pop_ok ? chull_pkg::S_H_DIFF : chull_pkg::S_H_PUSH;
      chull_pkg::S_H_DIFF: state_next = chull_pkg::S_H_MUL;
      chull_pkg::S_H_MUL:  state_next = chull_pkg::S_H_CMP;
      chull_pkg::S_H_CMP: begin
        if (!cw)                                 state_next = chull_pkg::S_H_PUSH;
        else if (depth >= chull_pkg::SDEP_W'(3)) state_next = chull_pkg::S_H_SLAT;
        else                                     state_next = chull_pkg::S_H_CHK;
      end
      chull_pkg::S_H_SLAT: state_next = chull_pkg::S_H_CHK;
      chull_pkg::S_H_PUSH: begin
        if (!upper) begin
          if (i + 1'b1 == count)
            state_next = (count >= chull_pkg::CNT_W'(2)) ? chull_pkg::S_H_RI : chull_pkg::S_EMIT;
          else
            state_next = chull_pkg::S_H_RI;
        end else begin
          state_next = (i == '0) ? chull_pkg::S_EMIT : chull_pkg::S_H_RI;
        end
      end
      chull_pkg::S_EMIT:  state_next = (e_cnt == '0) ? chull_pkg::S_IDLE : chull_pkg::S_E_RS;
      chull_pkg::S_E_RS:  state_next = chull_pkg::S_E_RP;
      chull_pkg::S_E_RP:  state_next = chull_pkg::S_E_OUT;
      chull_pkg::S_E_OUT: begin
        if (load_out)
          state_next = (chull_pkg::SDEP_W'(k) + 1'b1 == emit_n) ? chull_pkg::S_IDLE
                                                                : chull_pkg::S_E_RS;
      end
      default: state_next = chull_pkg::S_IDLE;
    endcase
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (state == chull_pkg::S_SORT_CHK && k == '0)
      pmem[0] <= '{x: cur.x, y: cur.y};
    if (state == chull_pkg::S_SORT_CMP)
      pmem[chull_pkg::IDX_W'(k)] <= precedes ? rd_a : '{x: cur.x, y: cur.y};
    if (state == chull_pkg::S_H_PUSH && can_push)
      smem[chull_pkg::SIDX_W'(depth)] <= chull_pkg::IDX_W'(i);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      chull_pkg::S_IDLE:   if (q_valid) begin cur <= q_item; k <= count; end
      chull_pkg::S_SORT_CMP: if (precedes) k <= k - 1'b1;
      chull_pkg::S_HINIT:  begin i <= '0; upper <= 1'b0; end
      chull_pkg::S_H_LAT:  pi <= rd_a;
      chull_pkg::S_H_DIFF: begin
        ax <= chull_pkg::DIFF_W'(rd_a.x) - chull_pkg::DIFF_W'(pi.x);
        ay <= chull_pkg::DIFF_W'(rd_a.y) - chull_pkg::DIFF_W'(pi.y);
        bx <= chull_pkg::DIFF_W'(rd_b.x) - chull_pkg::DIFF_W'(pi.x);
        by <= chull_pkg::DIFF_W'(rd_b.y) - chull_pkg::DIFF_W'(pi.y);
      end
      chull_pkg::S_H_MUL: begin
        m1 <= ax * by;
        m2 <= ay * bx;
      end
      chull_pkg::S_H_CMP:  if (cw) top_i <= sec_i;
      chull_pkg::S_H_SLAT: sec_i <= srd;
      chull_pkg::S_H_PUSH: begin
        sec_i <= top_i;
        top_i <= chull_pkg::IDX_W'(i);
        if (!upper) begin
          if (i + 1'b1 == count) begin
            t     <= depth_pushed;
            upper <= 1'b1;
            i     <= count - chull_pkg::CNT_W'(2);
          end else begin
            i <= i + 1'b1;
          end
        end else if (i != '0) begin
          i <= i - 1'b1;
        end
      end
      chull_pkg::S_EMIT:  begin emit_n <= e_cnt; k <= '0; end
      chull_pkg::S_E_OUT: if (load_out) k <= k + 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      depth <= '0;
    end else begin
      case (state)
        chull_pkg::S_IDLE: if (q_valid && full) ovf <= 1'b1;
        chull_pkg::S_SORT_CHK: if (k == '0) count <= count + 1'b1;
        chull_pkg::S_SORT_CMP: if (!precedes) count <= count + 1'b1;
        chull_pkg::S_HINIT:  depth <= '0;
        chull_pkg::S_H_CMP:  if (cw) depth <= depth - 1'b1;
        chull_pkg::S_H_PUSH: depth <= depth_pushed;
        chull_pkg::S_EMIT: begin
          if (e_cnt == '0) begin
            count <= '0;
            ovf   <= 1'b0;
            depth <= '0;
          end
        end
        chull_pkg::S_E_OUT: begin
          if (load_out && chull_pkg::SDEP_W'(k) + 1'b1 == emit_n) begin
            count <= '0;
            ovf   <= 1'b0;
            depth <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load_out) begin
      ov <= 1'b1;
    end else if (hull.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ov_pt   <= rd_a;
      ov_last <= (chull_pkg::SDEP_W'(k) + 1'b1 == emit_n);
      ov_ovf  <= ovf;
    end
  end

  assign hull.valid       = ov;
  assign hull.hull_x      = chull_pkg::FIELD_W'(ov_pt.x);
  assign hull.hull_y      = chull_pkg::FIELD_W'(ov_pt.y);
  assign hull.last_vertex = ov_last;
  assign hull.overflowed  = ov_ovf;

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= chull_pkg::SDEP_W'(chull_pkg::STACK_DEPTH))
    else $error("hull stack overfilled");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= chull_pkg::CNT_W'(chull_pkg::MAX_POINTS))
    else $error("point count above store size");

  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    (state == chull_pkg::S_H_CMP && cw) |=> depth == $past(depth) - 1'b1)
    else $error("pop did not drop the stack by one");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (state == chull_pkg::S_IDLE) |-> depth == '0)
    else $error("stack not empty between sets");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!ov || hull.ready))
    else $error("output register overwritten");
`endif

endmodule

// ===== hdl/convex_hull_monotone_chain_core.sv =====
// A point request is inserted into the sorted store by shifting larger points
// up one slot; the closing request then runs the lower and upper hull passes
// and emits the hull vertices one at a time through the output register.
// The engine takes a new point request only in its idle state, so it works
// on one point at a time. Reset clears the point count, stack fill and
// overflow flag; the stores need no clearing pass.
// ----------------------------------------------------------------------------
// convex_hull_monotone_chain_core
// Monotone chain convex hull: point queue in front, sort/hull engine behind.
// ----------------------------------------------------------------------------
module convex_hull_monotone_chain_core (
  input  logic        clk,
  input  logic        rst,
  chull_in_if.sink    pts,
  chull_out_if.source hull
);

  logic             q_valid;
  logic             q_ready;
  chull_pkg::item_t q_item;

  chull_front u_front (
    .clk     (clk),
    .rst     (rst),
    .pts     (pts),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  chull_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .hull    (hull)
  );

endmodule
